FILE: rtl/pud_pkg.sv
// ----------------------------------------------------------------------------
// Process usage delta package
// Shared constants, command and register codes, and transfer payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package pud_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS    = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = KEY_BITS + 128;

  localparam int SCALE       = 25600;
  localparam int CPU_W       = 15;
  localparam int MEM_W       = 16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] REG_PREV_TIME = 2'd0;
  localparam logic [1:0] REG_CUR_TIME  = 2'd1;
  localparam logic [1:0] REG_CORES     = 2'd2;
  localparam logic [1:0] REG_MEM_TOTAL = 2'd3;

  localparam logic [CPU_W-1:0] CPU_FULL = CPU_W'(SCALE);
  localparam logic [MEM_W-1:0] MEM_SAT  = '1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] entry_key;
    logic [63:0] kernel_ticks;
    logic [63:0] user_ticks;
    logic [47:0] resident_bytes;
  } pud_item_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu_percent;
    logic [MEM_W-1:0] memory_percent;
    logic             match_found;
  } pud_result_t;

endpackage

`default_nettype wire

FILE: rtl/pud_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/process_usage_delta_unit.sv
// ----------------------------------------------------------------------------
// Process usage delta unit
// Keeps the previous snapshot's per-process counters in a table and gives
// CPU and memory share for each evaluated entry of the current snapshot.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------
//   item     | start & !busy       | item   (pud_item_t)
//   result   | done, one cycle     | result (pud_result_t)
//   config   | cfg_we              | cfg_index, cfg_data
//
// Clear and load keep busy low.
// Evaluate scans the stored entries one entry per cycle through the RAM
// read port, then two bit-serial dividers produce 15 CPU and 16 memory
// quotient bits in parallel.
// Reset empties the table at once; the RAM itself is never cleared.
// The receiver cannot stall; done is raised for one cycle per result.
// ----------------------------------------------------------------------------
`default_nettype none

module process_usage_delta_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire pud_pkg::pud_item_t  item,
  output logic                     done,
  output pud_pkg::pud_result_t     result,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);

  import pud_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DELTA = 6'b000100,
    S_SETUP = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [63:0] prev_time;
  logic [63:0] cur_time;
  logic [10:0] cores;
  logic [47:0] phys_mem;

  pud_item_t           item_q;
  logic [63:0]         dwall;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  idx;
  logic                rd_vld;
  logic                found;
  logic [63:0]         prior_k;
  logic [63:0]         prior_u;

  logic                back;
  logic [64:0]         busy_sum;
  logic [74:0]         den;
  logic [62:0]         mnum;

  logic                cpu_ok;
  logic                cpu_clamp;
  logic                mem_zero;
  logic                mem_sat;
  logic [74:0]         crem;
  logic [14:0]         clow;
  logic [CPU_W-1:0]    cq;
  logic [47:0]         mrem;
  logic [15:0]         mlow;
  logic [MEM_W-1:0]    mq;
  logic [3:0]          step;

  logic                accept;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic [ENTRY_W-1:0]  rdata;
  logic                issue;
  logic                hit;
  logic [79:0]         cnum;
  logic [75:0]         crem2;
  logic [48:0]         mrem2;
  logic                cbit;
  logic                mbit;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign we     = accept && (item.cmd == CMD_LOAD) && (count < COUNT_W'(TABLE_DEPTH));
  assign waddr  = count[ADDR_W-1:0];
  assign wdata  = {item.entry_key[KEY_BITS-1:0], item.kernel_ticks, item.user_ticks};
  assign issue  = (state == S_SCAN) && (idx < count);
  assign hit    = rd_vld && (rdata[ENTRY_W-1 -: KEY_BITS] == item_q.entry_key[KEY_BITS-1:0]);
  assign cnum   = busy_sum * 80'(SCALE);
  assign crem2  = {crem, clow[14]};
  assign mrem2  = {mrem, mlow[15]};
  assign cbit   = (crem2 >= {1'b0, den});
  assign mbit   = (mrem2 >= {1'b0, phys_mem});

  pud_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      cur_time  <= '0;
      cores     <= '0;
      phys_mem  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PREV_TIME: prev_time <= cfg_data;
        REG_CUR_TIME:  cur_time  <= cfg_data;
        REG_CORES:     cores     <= cfg_data[10:0];
        REG_MEM_TOTAL: phys_mem  <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= (state == S_DONE);
      rd_vld <= issue;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_q <= item;
            idx    <= '0;
            dwall  <= (cur_time > prev_time) ? (cur_time - prev_time) : '0;
            if (item.cmd == CMD_CLEAR) begin
              count <= '0;
            end else if (we) begin
              count <= count + 1'b1;
            end else if (item.cmd == CMD_EVAL) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (hit) begin
            found   <= 1'b1;
            prior_k <= rdata[127:64];
            prior_u <= rdata[63:0];
            state   <= S_DELTA;
          end else if (!rd_vld && !issue) begin
            found   <= 1'b0;
            prior_k <= '0;
            prior_u <= '0;
            state   <= S_DELTA;
          end
        end
        S_DELTA: begin
          back     <= (item_q.kernel_ticks < prior_k) || (item_q.user_ticks < prior_u);
          busy_sum <= 65'(item_q.kernel_ticks - prior_k) + 65'(item_q.user_ticks - prior_u);
          den      <= dwall * 75'(cores);
          mnum     <= 63'(item_q.resident_bytes) * 63'(SCALE);
          state    <= S_SETUP;
        end
        S_SETUP: begin
          cpu_ok    <= found && !back && (den != '0);
          cpu_clamp <= ({10'b0, busy_sum} >= den);
          mem_zero  <= (phys_mem == '0);
          mem_sat   <= ({1'b0, mnum} >= {phys_mem, 16'b0});
          crem      <= 75'(cnum[79:15]);
          clow      <= cnum[14:0];
          mrem      <= 48'(mnum[62:16]);
          mlow      <= mnum[15:0];
          step      <= '0;
          state     <= S_DIV;
        end
        S_DIV: begin
          mrem <= mbit ? 48'(mrem2 - {1'b0, phys_mem}) : mrem2[47:0];
          mlow <= {mlow[14:0], 1'b0};
          mq   <= {mq[MEM_W-2:0], mbit};
          if (step < 4'(CPU_W)) begin
            crem <= cbit ? 75'(crem2 - {1'b0, den}) : crem2[74:0];
            clow <= {clow[13:0], 1'b0};
            cq   <= {cq[CPU_W-2:0], cbit};
          end
          step <= step + 1'b1;
          if (step == 4'(MEM_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          result.cpu_percent    <= !cpu_ok ? '0 : (cpu_clamp ? CPU_FULL : cq);
          result.memory_percent <= mem_zero ? '0 : (mem_sat ? MEM_SAT : mq);
          result.match_found    <= found;
          state                 <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pud_checker.sv
// ----------------------------------------------------------------------------
// Process usage delta checker
// Port-level properties of the unit, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire pud_pkg::pud_item_t   item,
  input wire logic                 done,
  input wire pud_pkg::pud_result_t result
);

  import pud_pkg::*;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for more than one cycle");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_EVAL) |=> busy)
    else $error("evaluate transfer did not raise busy");

  a_table_cmd_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd != CMD_EVAL) |=> !busy && !done)
    else $error("table command raised busy or a result");

  a_cpu_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.cpu_percent <= CPU_FULL)
    else $error("cpu share above full scale");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.match_found) |-> result.cpu_percent == '0)
    else $error("cpu share without a matching entry");

endmodule

bind process_usage_delta_unit pud_checker u_pud_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .item  (item),
  .done  (done),
  .result(result)
);

`default_nettype wire
